// ----- rtl/core/maze_flood_distance_planner_unit_macros.svh -----
// Assertion macros shared by the planner checker.
`ifndef MAZE_FLOOD_DISTANCE_PLANNER_UNIT_MACROS_SVH
`define MAZE_FLOOD_DISTANCE_PLANNER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MFDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MFDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mfdp_pkg.sv -----
// Shared types, codes and constants of the maze flood distance planner.
package mfdp_pkg;

  localparam int GRID_SIDE_DEF = 16;
  localparam int DIR_COUNT     = 4;
  localparam int DIST_W        = 8;
  localparam logic [DIST_W-1:0] DIST_MAX = 8'd255;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // operation codes carried on in_tuser
  localparam logic [1:0] MODE_WALLS = 2'd0;
  localparam logic [1:0] MODE_INIT  = 2'd1;
  localparam logic [1:0] MODE_FLOOD = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // direction codes
  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  // broadcast to every cell
  typedef struct packed {
    logic       init;
    logic       flood;
    logic       wr;
    logic [3:0] walls;
  } cell_ctrl_t;

  // what a query needs to see of one cell
  typedef struct packed {
    logic [DIST_W-1:0]                cur_dist;
    logic [DIR_COUNT-1:0]             open;
    logic [DIR_COUNT-1:0][DIST_W-1:0] nbr;
  } view_t;

endpackage

// ----- rtl/core/mfdp_cell.sv -----
// One grid cell: wall bits, distance and the local relaxation step.
module mfdp_cell
  import mfdp_pkg::*;
#(
  parameter bit GOAL = 1'b0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cell_ctrl_t                       ctrl,
  input  logic                             sel,
  input  logic [DIR_COUNT-1:0][DIST_W-1:0] nbr_dist,
  input  logic [DIR_COUNT-1:0]             nbr_in,
  output logic [DIST_W-1:0]                cur_dist,
  output logic [DIR_COUNT-1:0]             open
);

  localparam logic [DIST_W-1:0] DIST_START = GOAL ? '0 : DIST_MAX;

  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [3:0]        walls_r, walls_nxt;
  logic [DIST_W-1:0] relax;

  assign open     = ~walls_r & nbr_in;
  assign cur_dist = dist_r;

  // least of own distance and each open neighbor plus one, saturating
  always_comb begin
    logic [DIST_W-1:0] cand;
    relax = dist_r;
    for (int d = 0; d < DIR_COUNT; d++) begin
      cand = (nbr_dist[d] == DIST_MAX) ? DIST_MAX : nbr_dist[d] + 1'b1;
      if (open[d] && (cand < relax)) begin
        relax = cand;
      end
    end
  end

  always_comb begin
    dist_nxt  = dist_r;
    walls_nxt = walls_r;
    if (ctrl.init) begin
      dist_nxt = DIST_START;
    end else if (ctrl.flood) begin
      dist_nxt = relax;
    end
    if (ctrl.wr && sel) begin
      walls_nxt = ctrl.walls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r  <= DIST_START;
      walls_r <= '0;
    end else begin
      dist_r  <= dist_nxt;
      walls_r <= walls_nxt;
    end
  end

endmodule

// ----- rtl/core/mfdp_reader.sv -----
// Two-stage registered select of one cell's view: column first, then row.
module mfdp_reader
  import mfdp_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  localparam int CW       = $clog2(GRID_SIDE)
) (
  input  logic          clk,
  input  view_t         views [GRID_SIDE][GRID_SIDE],
  input  logic [CW-1:0] col_i,
  input  logic [CW-1:0] row_i,
  output view_t         sel
);

  view_t row_r [GRID_SIDE];
  view_t sel_r;

  always_ff @(posedge clk) begin
    for (int r = 0; r < GRID_SIDE; r++) begin
      row_r[r] <= views[r][col_i];
    end
    sel_r <= row_r[row_i];
  end

  assign sel = sel_r;

endmodule

// ----- rtl/core/maze_flood_distance_planner_unit.sv -----
// Top level of the maze flood distance planner: cell array, control and stream ports.
//
// The block keeps a GRID_SIDE x GRID_SIDE maze as an array of cells, one per
// grid square, each holding its four wall bits and its 8-bit distance to the goal and
// wired to its four neighbors. Every transaction on the input stream gives exactly one
// result transaction. in_tuser selects the operation: write a cell's walls, initialize
// the distances (all 255, the four center cells 0), flood, or query the open neighbor
// of least distance in the order preferred, left, right, back. A flood relaxes every
// cell at once in each cycle against its open neighbors plus one (saturating at 255)
// and always runs GRID_SIDE*GRID_SIDE such sweeps, enough for the longest possible
// path. Each operation runs in the operation state; then the registered column and
// row select fetches the addressed cell, and the result goes into the output register.
// The input is ready again in the cycle after the result is loaded. One item is worked
// on at a time; a new transaction is taken as soon as the previous result sits in the
// output register, even if it is not yet drained. Neighbors outside the grid count as
// walled, a wall write to a cell outside the grid is dropped and such a cell reads
// back 255. The cells, the control state and the output valid reset synchronously;
// there is no clearing pass.
module maze_flood_distance_planner_unit
  import mfdp_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata, lowest bit up: cell_x[3:0], cell_y[3:0], wall_bits[3:0], prefer_dir[1:0], pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: mode[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata, lowest bit up: best_dir[1:0], cell_distance[7:0], pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CW     = $clog2(GRID_SIDE);
  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int CNTW   = $clog2(CELLS);
  localparam int CENTER = GRID_SIDE / 2;
  localparam logic [CNTW-1:0] SWEEP_LAST = CNTW'(CELLS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OP   = 3'd1;
  localparam logic [2:0] ST_RD1  = 3'd2;
  localparam logic [2:0] ST_RD2  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  // latched item
  logic [1:0] mode_r;
  logic [3:0] x_r, y_r, walls_r;
  logic [1:0] prefer_r;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_dir_r, out_dir_nxt;
  logic [7:0] out_dist_r, out_dist_nxt;

  logic          in_acc;
  logic          on_grid;
  logic          out_load;
  logic [CW-1:0] col_i, row_i;
  cell_ctrl_t    ctrl;

  logic [DIST_W-1:0]    dist_w [GRID_SIDE][GRID_SIDE];
  logic [DIR_COUNT-1:0] open_w [GRID_SIDE][GRID_SIDE];
  logic [DIR_COUNT-1:0][DIST_W-1:0] nbr_w [GRID_SIDE][GRID_SIDE];
  view_t view_w [GRID_SIDE][GRID_SIDE];
  view_t sel_view;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign on_grid = (32'(x_r) < GRID_SIDE) && (32'(y_r) < GRID_SIDE);
  assign col_i   = CW'(x_r);
  assign row_i   = CW'(y_r);

  // drive the cells only in the operation cycle(s)
  always_comb begin
    ctrl       = '0;
    ctrl.walls = walls_r;
    if (state_r == ST_OP) begin
      ctrl.wr    = (mode_r == MODE_WALLS) && on_grid;
      ctrl.init  = (mode_r == MODE_INIT);
      ctrl.flood = (mode_r == MODE_FLOOD);
    end
  end

  // cell array with nearest-neighbor links; off-grid links read as walled 255
  for (genvar gy = 0; gy < GRID_SIDE; gy++) begin : g_row
    for (genvar gx = 0; gx < GRID_SIDE; gx++) begin : g_col
      localparam bit GOAL = ((gx == CENTER) || (gx == CENTER - 1)) &&
                            ((gy == CENTER) || (gy == CENTER - 1));
      logic [DIR_COUNT-1:0] nbr_in;

      if (gy + 1 < GRID_SIDE) begin : g_n
        assign nbr_w[gy][gx][DIR_NORTH] = dist_w[gy+1][gx];
        assign nbr_in[DIR_NORTH]        = 1'b1;
      end else begin : g_n_edge
        assign nbr_w[gy][gx][DIR_NORTH] = DIST_MAX;
        assign nbr_in[DIR_NORTH]        = 1'b0;
      end
      if (gx + 1 < GRID_SIDE) begin : g_e
        assign nbr_w[gy][gx][DIR_EAST] = dist_w[gy][gx+1];
        assign nbr_in[DIR_EAST]        = 1'b1;
      end else begin : g_e_edge
        assign nbr_w[gy][gx][DIR_EAST] = DIST_MAX;
        assign nbr_in[DIR_EAST]        = 1'b0;
      end
      if (gy > 0) begin : g_s
        assign nbr_w[gy][gx][DIR_SOUTH] = dist_w[gy-1][gx];
        assign nbr_in[DIR_SOUTH]        = 1'b1;
      end else begin : g_s_edge
        assign nbr_w[gy][gx][DIR_SOUTH] = DIST_MAX;
        assign nbr_in[DIR_SOUTH]        = 1'b0;
      end
      if (gx > 0) begin : g_w
        assign nbr_w[gy][gx][DIR_WEST] = dist_w[gy][gx-1];
        assign nbr_in[DIR_WEST]        = 1'b1;
      end else begin : g_w_edge
        assign nbr_w[gy][gx][DIR_WEST] = DIST_MAX;
        assign nbr_in[DIR_WEST]        = 1'b0;
      end

      mfdp_cell #(
        .GOAL(GOAL)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sel     ((col_i == CW'(gx)) && (row_i == CW'(gy))),
        .nbr_dist(nbr_w[gy][gx]),
        .nbr_in  (nbr_in),
        .cur_dist(dist_w[gy][gx]),
        .open    (open_w[gy][gx])
      );

      assign view_w[gy][gx].cur_dist = dist_w[gy][gx];
      assign view_w[gy][gx].open     = open_w[gy][gx];
      assign view_w[gy][gx].nbr      = nbr_w[gy][gx];
    end
  end

  // fetch the addressed cell: column in RD1, row in RD2, valid in OUT
  mfdp_reader #(
    .GRID_SIDE(GRID_SIDE)
  ) u_reader (
    .clk  (clk),
    .views(view_w),
    .col_i(col_i),
    .row_i(row_i),
    .sel  (sel_view)
  );

  // control sequence
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = ST_OP;
        end
      end
      ST_OP: begin
        // a flood holds here for one sweep per cell
        if ((mode_r != MODE_FLOOD) || (cnt_r == SWEEP_LAST)) begin
          state_nxt = ST_RD1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RD1: state_nxt = ST_RD2;
      ST_RD2: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // best neighbor: try preferred, left, right, back; strict less-than keeps the earlier
  always_comb begin
    logic [1:0]        d;
    logic [1:0]        choice;
    logic [DIST_W-1:0] best;
    logic [1:0]        order [DIR_COUNT];
    order[0] = prefer_r;
    order[1] = prefer_r + 2'd3;
    order[2] = prefer_r + 2'd1;
    order[3] = prefer_r + 2'd2;
    best     = DIST_MAX;
    choice   = prefer_r;
    for (int i = 0; i < DIR_COUNT; i++) begin
      d = order[i];
      if (sel_view.open[d] && (sel_view.nbr[d] < best)) begin
        best   = sel_view.nbr[d];
        choice = d;
      end
    end

    if (mode_r != MODE_QUERY) begin
      out_dir_nxt = '0;
    end else if (!on_grid) begin
      out_dir_nxt = prefer_r;
    end else begin
      out_dir_nxt = choice;
    end
    out_dist_nxt = on_grid ? sel_view.cur_dist : DIST_MAX;
  end

  // output register: hold until taken, drop valid on handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r   <= in_tuser[1:0];
      x_r      <= in_tdata[3:0];
      y_r      <= in_tdata[7:4];
      walls_r  <= in_tdata[11:8];
      prefer_r <= in_tdata[13:12];
    end
    if (out_load) begin
      out_dir_r  <= out_dir_nxt;
      out_dist_r <= out_dist_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 10){1'b0}}, out_dist_r, out_dir_r};

endmodule

// ----- rtl/core/maze_flood_distance_planner_unit_checker.sv -----
// Port-level checker for the planner and its bind to the top level.
`include "maze_flood_distance_planner_unit_macros.svh"

module maze_flood_distance_planner_unit_checker
  import mfdp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds its value
  `MFDP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // an accepted transaction keeps the input side busy in the following cycle
  `MFDP_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input ready right after accept")

  // a new result only appears after a busy cycle
  `MFDP_ASSERT_IMP(a_result_after_work, $rose(out_tvalid), !$past(in_tready), "result without work")

  // padding above cell_distance stays zero
  `MFDP_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[OUT_TDATA_W-1:10] == '0, "nonzero pad bits")

endmodule

bind maze_flood_distance_planner_unit maze_flood_distance_planner_unit_checker u_checker (.*);

// ----- test/tb_maze_flood_distance_planner_unit.sv -----
// Testbench for the maze flood distance planner: directed table, then random episodes.
`timescale 1ns / 1ps

module tb_maze_flood_distance_planner_unit;
  import mfdp_pkg::*;

  localparam int SIDE        = GRID_SIDE_DEF;
  localparam int CELLS       = SIDE * SIDE;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 300;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] cx;
    logic [3:0] cy;
    logic [3:0] walls;
    logic [1:0] pref;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        dir;
    logic [DIST_W-1:0] cell_dist;
  } reading_t;

  typedef struct packed {
    cmd_t     cmd;
    bit       typed;
    reading_t want;
  } row_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // maze copy kept by the testbench
  logic [DIST_W-1:0] dist_copy [CELLS];
  logic [3:0]        wall_copy [CELLS];

  reading_t reading_q[$];
  row_t     steps[$];
  int       errors      = 0;
  int       idle_pct    = 0;
  int       stall_pct   = 0;
  bit       hold_req    = 1'b0;
  int       hold_left   = 0;
  int       cycle_count = 0;

  maze_flood_distance_planner_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void reset_distances();
    for (int i = 0; i < CELLS; i++) dist_copy[i] = DIST_MAX;
    dist_copy[(SIDE/2) * SIDE + SIDE/2]         = '0;
    dist_copy[(SIDE/2) * SIDE + SIDE/2 - 1]     = '0;
    dist_copy[(SIDE/2 - 1) * SIDE + SIDE/2]     = '0;
    dist_copy[(SIDE/2 - 1) * SIDE + SIDE/2 - 1] = '0;
  endfunction

  // Index of the neighbor in direction d; zero return when it lies off the grid.
  function automatic bit neighbor_at(input int x, input int y, input logic [1:0] d,
                                     output int idx);
    int nx, ny;
    nx = x;
    ny = y;
    case (d)
      DIR_NORTH: ny++;
      DIR_EAST:  nx++;
      DIR_SOUTH: ny--;
      default:   nx--;
    endcase
    idx = ny * SIDE + nx;
    return !(nx < 0 || ny < 0 || nx >= SIDE || ny >= SIDE);
  endfunction

  // Relax every cell against its open neighbors plus one until the map settles.
  function automatic void relax_map();
    bit                changed;
    int                here, nb;
    logic [DIST_W-1:0] best, v;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int y = 0; y < SIDE; y++) begin
        for (int x = 0; x < SIDE; x++) begin
          here = y * SIDE + x;
          best = dist_copy[here];
          for (int d = 0; d < DIR_COUNT; d++) begin
            if (!wall_copy[here][d] && neighbor_at(x, y, 2'(d), nb)) begin
              v = (dist_copy[nb] == DIST_MAX) ? DIST_MAX : dist_copy[nb] + 8'd1;
              if (v < best) best = v;
            end
          end
          if (best < dist_copy[here]) begin
            dist_copy[here] = best;
            changed = 1'b1;
          end
        end
      end
    end
  endfunction

  // Preferred, left, right, back; strict less-than keeps the earlier direction.
  function automatic logic [1:0] pick_direction(input int x, input int y, input logic [1:0] p);
    logic [1:0]        order [4];
    logic [1:0]        choice;
    logic [DIST_W-1:0] best;
    int                here, nb;
    order[0] = p;
    order[1] = p + 2'd3;
    order[2] = p + 2'd1;
    order[3] = p + 2'd2;
    choice   = p;
    best     = DIST_MAX;
    here     = y * SIDE + x;
    for (int i = 0; i < DIR_COUNT; i++) begin
      if (!wall_copy[here][order[i]] && neighbor_at(x, y, order[i], nb)) begin
        if (dist_copy[nb] < best) begin
          best   = dist_copy[nb];
          choice = order[i];
        end
      end
    end
    return choice;
  endfunction

  function automatic reading_t planner_step(input cmd_t c);
    reading_t r;
    int       here;
    here  = int'(c.cy) * SIDE + int'(c.cx);
    r.dir = DIR_NORTH;
    case (c.mode)
      MODE_WALLS: wall_copy[here] = c.walls;
      MODE_INIT:  reset_distances();
      MODE_FLOOD: relax_map();
      default:    r.dir = pick_direction(int'(c.cx), int'(c.cy), c.pref);
    endcase
    r.cell_dist = dist_copy[here];
    return r;
  endfunction

  function automatic void check_reading(input logic [OUT_TDATA_W-1:0] word);
    reading_t want;
    if (reading_q.size() == 0) begin
      $display("%0t: result with nothing expected, got tdata %h", $time, word);
      errors++;
      return;
    end
    want = reading_q.pop_front();
    if (word[1:0] !== want.dir) begin
      $display("%0t: best_dir mismatch, expected %0d, actual %0d", $time, want.dir, word[1:0]);
      errors++;
    end
    if (word[9:2] !== want.cell_dist) begin
      $display("%0t: cell_distance mismatch, expected %0d, actual %0d",
               $time, want.cell_dist, word[9:2]);
      errors++;
    end
  endfunction

  // Result side: check each transaction, then choose tready for the next edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_reading(out_tdata);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic sender_gap();
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one transaction, wait for the handshake, then record what it should return.
  task automatic issue(input cmd_t c, input bit typed, input reading_t want);
    reading_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= c.mode;
    in_tdata  <= {2'b00, c.pref, c.walls, c.cy, c.cx};
    do @(posedge clk); while (!in_tready);
    predicted = planner_step(c);
    reading_q.push_back(typed ? want : predicted);
    sender_gap();
  endtask

  task automatic issue_predicted(input logic [1:0] mode, input logic [3:0] x,
                                 input logic [3:0] y, input logic [3:0] walls,
                                 input logic [1:0] pref);
    issue('{mode, x, y, walls, pref}, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(input logic [1:0] mode, input logic [3:0] x,
                                  input logic [3:0] y, input logic [3:0] walls,
                                  input logic [1:0] pref, input bit typed,
                                  input logic [1:0] dir, input logic [7:0] want_dist);
    steps.push_back('{'{mode, x, y, walls, pref}, typed, '{dir, want_dist}});
  endfunction

  function automatic logic [3:0] sparse_walls();
    logic [3:0] w;
    if ($urandom_range(3) == 0) return 4'($urandom_range(15));
    for (int b = 0; b < 4; b++) w[b] = ($urandom_range(3) == 0);
    return w;
  endfunction

  initial begin
    int sent, phase, q;
    for (int i = 0; i < CELLS; i++) wall_copy[i] = '0;
    reset_distances();

    // after reset, extremes, walled pockets and saturation
    add_row(MODE_QUERY, 4'd0,  4'd0,  4'h0, DIR_NORTH, 1, DIR_NORTH, 8'd255);
    add_row(MODE_QUERY, 4'd7,  4'd7,  4'h0, DIR_SOUTH, 1, DIR_EAST,  8'd0);
    add_row(MODE_QUERY, 4'd15, 4'd15, 4'hF, DIR_EAST,  1, DIR_EAST,  8'd255);
    add_row(MODE_QUERY, 4'd8,  4'd8,  4'h0, DIR_WEST,  1, DIR_WEST,  8'd0);
    add_row(MODE_FLOOD, 4'd0,  4'd0,  4'h0, DIR_NORTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd0,  4'd0,  4'h0, DIR_WEST,  0, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd15, 4'd0,  4'h0, DIR_SOUTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_WALLS, 4'd8,  4'd8,  4'hF, DIR_NORTH, 1, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd8,  4'd8,  4'h0, DIR_NORTH, 1, DIR_NORTH, 8'd0);
    add_row(MODE_WALLS, 4'd0,  4'd15, 4'h6, DIR_NORTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_WALLS, 4'd15, 4'd0,  4'hF, DIR_WEST,  0, DIR_NORTH, 8'd0);
    add_row(MODE_INIT,  4'd15, 4'd0,  4'h0, DIR_NORTH, 1, DIR_NORTH, 8'd255);
    add_row(MODE_FLOOD, 4'd0,  4'd15, 4'h0, DIR_NORTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd0,  4'd14, 4'h0, DIR_NORTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd15, 4'd0,  4'h0, DIR_WEST,  0, DIR_NORTH, 8'd0);
    add_row(MODE_WALLS, 4'd0,  4'd15, 4'h0, DIR_NORTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_WALLS, 4'd3,  4'd4,  4'hA, DIR_NORTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_FLOOD, 4'd3,  4'd4,  4'h0, DIR_NORTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd3,  4'd4,  4'h0, DIR_NORTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd3,  4'd4,  4'h0, DIR_EAST,  0, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd3,  4'd4,  4'h0, DIR_SOUTH, 0, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd3,  4'd4,  4'h0, DIR_WEST,  0, DIR_NORTH, 8'd0);
    add_row(MODE_INIT,  4'd7,  4'd8,  4'h0, DIR_NORTH, 1, DIR_NORTH, 8'd0);
    add_row(MODE_QUERY, 4'd7,  4'd8,  4'h0, DIR_EAST,  1, DIR_EAST,  8'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) issue(steps[i].cmd, steps[i].typed, steps[i].want);
    drain_results();

    // phases: no idling, sender idle, receiver stall (with a long hold), both
    sent = 0;
    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 50 : (phase == 3) ? 37 : 0;
      stall_pct = (phase == 2) ? 50 : (phase == 3) ? 37 : 0;
      if (phase == 2) hold_req = 1'b1;
      while (sent < (phase + 1) * RANDOM_ITEMS / 4) begin
        if ($urandom_range(99) < 15) begin
          // noise: any operation at any cell
          issue_predicted(2'($urandom_range(3)), 4'($urandom_range(15)),
                          4'($urandom_range(15)), 4'($urandom_range(15)),
                          2'($urandom_range(3)));
          sent++;
        end else begin
          // episode: maybe restart the distances, learn walls, flood, then ask
          if ($urandom_range(3) == 0) begin
            issue_predicted(MODE_INIT, 4'($urandom_range(15)), 4'($urandom_range(15)),
                            4'($urandom_range(15)), 2'($urandom_range(3)));
            sent++;
          end
          q = $urandom_range(1, 10);
          repeat (q) begin
            issue_predicted(MODE_WALLS, 4'($urandom_range(15)), 4'($urandom_range(15)),
                            sparse_walls(), 2'($urandom_range(3)));
            sent++;
          end
          issue_predicted(MODE_FLOOD, 4'($urandom_range(15)), 4'($urandom_range(15)),
                          4'($urandom_range(15)), 2'($urandom_range(3)));
          sent++;
          q = $urandom_range(1, 6);
          repeat (q) begin
            issue_predicted(MODE_QUERY, 4'($urandom_range(15)), 4'($urandom_range(15)),
                            4'($urandom_range(15)), 2'($urandom_range(3)));
            sent++;
          end
        end
      end
      // pause the sender until every outstanding result has come back
      drain_results();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && reading_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- maze_flood_distance_planner_unit.f -----
+incdir+rtl/core
rtl/core/mfdp_pkg.sv
rtl/core/mfdp_cell.sv
rtl/core/mfdp_reader.sv
rtl/core/maze_flood_distance_planner_unit.sv
rtl/core/maze_flood_distance_planner_unit_checker.sv
test/tb_maze_flood_distance_planner_unit.sv
